// ----- src/ffd_pkg.sv -----
package ffd_pkg;

	localparam int TABLE_DEPTH_DEF = 128;
	localparam int CELL_GROUP      = 16;

	localparam int ETYPE_W = 16;
	localparam int MAC_W   = 48;
	localparam int IP_W    = 32;
	localparam int SEQ_W   = 32;
	localparam int CNT_W   = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 48;

	localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;
	localparam logic [CNT_W-1:0] CNT_ONE = 8'h01;

	localparam logic [CFG_IDX_W-1:0] REG_FLOOD_ETYPE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_IP      = 2'd2;

	typedef enum logic [2:0] {
		V_BAD_TYPE  = 3'd0,
		V_OWN_FRAME = 3'd1,
		V_DUPLICATE = 3'd2,
		V_DELIVER   = 3'd3,
		V_FORWARD   = 3'd4
	} verdict_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_RES
	} state_t;

	typedef struct packed {
		logic             valid;
		logic [IP_W-1:0]  origin;
		logic [SEQ_W-1:0] seq;
		logic [CNT_W-1:0] count;
	} entry_t;

	typedef struct packed {
		logic cmp;
		logic bump;
		logic shift;
	} ctl_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		return (c == CNT_MAX) ? CNT_MAX : c + CNT_ONE;
	endfunction

endpackage

// ----- src/ffd_if.sv -----
interface ffd_pkt_if;
	logic                        valid;
	logic                        ready;
	logic [ffd_pkg::ETYPE_W-1:0] pkt_ethertype;
	logic [ffd_pkg::MAC_W-1:0]   sender_mac;
	logic [ffd_pkg::IP_W-1:0]    origin_addr;
	logic [ffd_pkg::IP_W-1:0]    query_dst;
	logic [ffd_pkg::SEQ_W-1:0]   flood_seq;

	modport source (output valid, pkt_ethertype, sender_mac, origin_addr, query_dst,
		flood_seq, input ready);
	modport sink (input valid, pkt_ethertype, sender_mac, origin_addr, query_dst,
		flood_seq, output ready);
endinterface

interface ffd_res_if;
	logic                      valid;
	logic                      ready;
	logic [2:0]                verdict;
	logic [ffd_pkg::CNT_W-1:0] seen_count;

	modport source (output valid, verdict, seen_count, input ready);
	modport sink (input valid, verdict, seen_count, output ready);
endinterface

// ----- src/ffd_cell.sv -----
module ffd_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ffd_pkg::ctl_t             ctl,
	input  logic [ffd_pkg::IP_W-1:0]  key_origin,
	input  logic [ffd_pkg::SEQ_W-1:0] key_seq,
	input  ffd_pkg::entry_t           prev,
	output ffd_pkg::entry_t           entry,
	output logic [ffd_pkg::CNT_W-1:0] report
);

	logic                      valid_q;
	logic [ffd_pkg::IP_W-1:0]  origin_q;
	logic [ffd_pkg::SEQ_W-1:0] seq_q;
	logic [ffd_pkg::CNT_W-1:0] count_q;
	logic                      hit_q;
	logic                      hit_c;

	assign hit_c  = valid_q && (origin_q == key_origin) && (seq_q == key_seq);
	assign report = hit_c ? ffd_pkg::sat_inc(count_q) : '0;

	assign entry.valid  = valid_q;
	assign entry.origin = origin_q;
	assign entry.seq    = seq_q;
	assign entry.count  = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			if (ctl.cmp) begin
				hit_q <= hit_c;
			end
			if (ctl.shift) begin
				valid_q <= prev.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			origin_q <= prev.origin;
			seq_q    <= prev.seq;
			count_q  <= prev.count;
		end else if (ctl.bump && hit_q) begin
			count_q <= ffd_pkg::sat_inc(count_q);
		end
	end

endmodule

// ----- src/ffd_chain.sv -----
module ffd_chain #(
	parameter int TABLE_DEPTH = ffd_pkg::TABLE_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ffd_pkg::ctl_t             ctl,
	input  logic [ffd_pkg::IP_W-1:0]  key_origin,
	input  logic [ffd_pkg::SEQ_W-1:0] key_seq,
	output logic                      hit,
	output logic [ffd_pkg::CNT_W-1:0] hit_count
);

	localparam int NGRP = (TABLE_DEPTH + ffd_pkg::CELL_GROUP - 1) / ffd_pkg::CELL_GROUP;

	ffd_pkg::entry_t           ent  [TABLE_DEPTH+1];
	logic [ffd_pkg::CNT_W-1:0] rep  [TABLE_DEPTH];
	logic [ffd_pkg::CNT_W-1:0] grp_c [NGRP];
	logic [ffd_pkg::CNT_W-1:0] grp_q [NGRP];

	assign ent[0].valid  = 1'b1;
	assign ent[0].origin = key_origin;
	assign ent[0].seq    = key_seq;
	assign ent[0].count  = ffd_pkg::CNT_ONE;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		ffd_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.key_origin (key_origin),
			.key_seq    (key_seq),
			.prev       (ent[i]),
			.entry      (ent[i+1]),
			.report     (rep[i])
		);
	end

	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_c[g] = '0;
		end
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			grp_c[i / ffd_pkg::CELL_GROUP] = grp_c[i / ffd_pkg::CELL_GROUP] | rep[i];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.cmp) begin
			grp_q <= grp_c;
		end
	end

	always_comb begin
		hit_count = '0;
		for (int g = 0; g < NGRP; g++) begin
			hit_count = hit_count | grp_q[g];
		end
	end

	assign hit = |hit_count;

endmodule

// ----- src/flood_duplicate_filter.sv -----
// Channel  Dir  Payload                                                  Transaction
// pkt_in   in   pkt_ethertype sender_mac origin_addr query_dst flood_seq valid & ready
// res_out  out  verdict seen_count                                       valid & ready
// cfg      in   cfg_idx cfg_wdata                                        cfg_we
//
// Per packet, ST_CMP compares the key against every cell of the chain, then ST_RES combines
// the group hits and, unless the packet was dropped early, updates the chain (bump on a hit,
// shift-insert on a miss). A new packet can be accepted in ST_RES, overlapping the update.
// Reset clears all valid bits at once; no clearing pass.
// A stalled res_out holds the update cycle until the output register frees up.
module flood_duplicate_filter #(
	parameter int TABLE_DEPTH = ffd_pkg::TABLE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	ffd_pkt_if.sink                        pkt_in,
	ffd_res_if.source                      res_out,
	input  logic                           cfg_we,
	input  logic [ffd_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [ffd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	logic [ffd_pkg::ETYPE_W-1:0] flood_etype_q;
	logic [ffd_pkg::MAC_W-1:0]   own_mac_q;
	logic [ffd_pkg::IP_W-1:0]    own_ip_q;

	ffd_pkg::state_t state_q, state_d;

	logic                      early_q;
	ffd_pkg::verdict_t         early_v_q;
	logic                      fwd_q;
	logic [ffd_pkg::IP_W-1:0]  origin_q;
	logic [ffd_pkg::SEQ_W-1:0] seq_q;

	logic                      out_valid_q;
	ffd_pkg::verdict_t         verdict_q;
	logic [ffd_pkg::CNT_W-1:0] seen_count_q;

	logic                      accept;
	logic                      res_go;
	logic                      hit;
	logic [ffd_pkg::CNT_W-1:0] hit_count;
	ffd_pkg::ctl_t             ctl;

	assign res_go = (state_q == ffd_pkg::ST_RES) && (!out_valid_q || res_out.ready);
	assign accept = pkt_in.valid && pkt_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flood_etype_q <= '0;
			own_mac_q     <= '0;
			own_ip_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				ffd_pkg::REG_FLOOD_ETYPE: flood_etype_q <= cfg_wdata[ffd_pkg::ETYPE_W-1:0];
				ffd_pkg::REG_OWN_MAC:     own_mac_q     <= cfg_wdata[ffd_pkg::MAC_W-1:0];
				ffd_pkg::REG_OWN_IP:      own_ip_q      <= cfg_wdata[ffd_pkg::IP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		pkt_in.ready = 1'b0;
		ctl.cmp      = 1'b0;
		ctl.bump     = 1'b0;
		ctl.shift    = 1'b0;
		unique case (state_q)
			ffd_pkg::ST_IDLE: begin
				pkt_in.ready = 1'b1;
				if (pkt_in.valid) state_d = ffd_pkg::ST_CMP;
			end
			ffd_pkg::ST_CMP: begin
				ctl.cmp = 1'b1;
				state_d = ffd_pkg::ST_RES;
			end
			ffd_pkg::ST_RES: begin
				if (res_go) begin
					pkt_in.ready = 1'b1;
					ctl.bump     = !early_q && hit;
					ctl.shift    = !early_q && !hit;
					state_d      = pkt_in.valid ? ffd_pkg::ST_CMP : ffd_pkg::ST_IDLE;
				end
			end
			default: state_d = ffd_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			early_q   <= (pkt_in.pkt_ethertype != flood_etype_q) ||
				(pkt_in.sender_mac == own_mac_q);
			early_v_q <= (pkt_in.pkt_ethertype != flood_etype_q) ?
				ffd_pkg::V_BAD_TYPE : ffd_pkg::V_OWN_FRAME;
			fwd_q     <= pkt_in.query_dst != own_ip_q;
			origin_q  <= pkt_in.origin_addr;
			seq_q     <= pkt_in.flood_seq;
		end
	end

	ffd_chain #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_chain (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.key_origin (origin_q),
		.key_seq    (seq_q),
		.hit        (hit),
		.hit_count  (hit_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_go) begin
			out_valid_q <= 1'b1;
		end else if (res_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_go) begin
			if (early_q) begin
				verdict_q    <= early_v_q;
				seen_count_q <= '0;
			end else if (hit) begin
				verdict_q    <= ffd_pkg::V_DUPLICATE;
				seen_count_q <= hit_count;
			end else begin
				verdict_q    <= fwd_q ? ffd_pkg::V_FORWARD : ffd_pkg::V_DELIVER;
				seen_count_q <= ffd_pkg::CNT_ONE;
			end
		end
	end

	assign res_out.valid      = out_valid_q;
	assign res_out.verdict    = verdict_q;
	assign res_out.seen_count = seen_count_q;

`ifndef SYNTH
	a_accept_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ffd_pkg::ST_CMP)
		else $error("accepted transaction did not start a compare");
	a_cmp_res: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ffd_pkg::ST_CMP |=> state_q == ffd_pkg::ST_RES)
		else $error("compare not followed by update");
	a_dup_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && verdict_q == ffd_pkg::V_DUPLICATE |-> seen_count_q >= 8'd2)
		else $error("duplicate reported with count below two");
	a_early_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (verdict_q == ffd_pkg::V_BAD_TYPE || verdict_q == ffd_pkg::V_OWN_FRAME)
		|-> seen_count_q == '0)
		else $error("early drop with nonzero count");
`endif

endmodule

// ----- tb/sv/flood_duplicate_filter_tb.sv -----
module flood_duplicate_filter_tb;

	localparam int DEPTH = ffd_pkg::TABLE_DEPTH_DEF;
	localparam int GAP_MAX = 12;
	localparam int WATCHDOG_LIMIT = 500;
	localparam int TAIL_CYCLES = 20;
	localparam int HISTORY_MAX = 200;
	localparam int PHASES = 7;
	localparam int HAMMER_PHASE = 3;
	localparam int HAMMER_ITEMS = 270;
	localparam int PHASE_ITEMS = 128;
	localparam logic [ffd_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;

	typedef struct packed {
		logic [ffd_pkg::ETYPE_W-1:0] etype;
		logic [ffd_pkg::MAC_W-1:0]   mac;
		logic [ffd_pkg::IP_W-1:0]    origin;
		logic [ffd_pkg::IP_W-1:0]    qdst;
		logic [ffd_pkg::SEQ_W-1:0]   seq;
	} hdr_t;

	typedef struct packed {
		ffd_pkg::verdict_t         verdict;
		logic [ffd_pkg::CNT_W-1:0] count;
	} screen_res_t;

	typedef struct packed {
		logic [ffd_pkg::IP_W-1:0]  origin;
		logic [ffd_pkg::SEQ_W-1:0] seq;
	} flood_key_t;

	typedef enum bit {STEP_CFG, STEP_PKT} step_kind_t;

	typedef struct {
		step_kind_t                     kind;
		logic [ffd_pkg::CFG_IDX_W-1:0]  idx;
		logic [ffd_pkg::CFG_DATA_W-1:0] wdata;
		hdr_t                           hdr;
		bit                             fixed;
		ffd_pkg::verdict_t              verdict;
		logic [ffd_pkg::CNT_W-1:0]      count;
	} step_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [ffd_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [ffd_pkg::CFG_DATA_W-1:0] cfg_wdata;

	ffd_pkt_if pkt_in ();
	ffd_res_if res_out ();

	flood_duplicate_filter #(.TABLE_DEPTH(DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_in    (pkt_in),
		.res_out   (res_out),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	logic [ffd_pkg::ETYPE_W-1:0] cur_etype = '0;
	logic [ffd_pkg::MAC_W-1:0]   cur_mac = '0;
	logic [ffd_pkg::IP_W-1:0]    cur_ip = '0;

	logic [ffd_pkg::IP_W-1:0]  cache_origin [DEPTH];
	logic [ffd_pkg::SEQ_W-1:0] cache_seq [DEPTH];
	logic [ffd_pkg::CNT_W-1:0] cache_hits [DEPTH];
	bit                        cache_live [DEPTH];
	int unsigned               cache_oldest = 0;
	int unsigned               cache_fill = 0;

	screen_res_t pending [$];
	flood_key_t  recent_keys [$];
	step_t       script [26];

	bit src_busy = 1'b1;
	bit snk_busy = 1'b1;
	int unsigned sink_wait = 0;
	int unsigned idle_cycles = 0;
	int fails = 0;
	int headers_sent = 0;
	int reg_writes = 0;
	int evictions = 0;
	int saturated_hits = 0;
	int verdict_tally [5];

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic void screen_header(input hdr_t h, output ffd_pkg::verdict_t v,
		output logic [ffd_pkg::CNT_W-1:0] n);
		int hit;
		int unsigned slot;
		hit = -1;
		if (h.etype != cur_etype) begin
			v = ffd_pkg::V_BAD_TYPE;
			n = '0;
		end else if (h.mac == cur_mac) begin
			v = ffd_pkg::V_OWN_FRAME;
			n = '0;
		end else begin
			for (int i = 0; i < DEPTH; i++)
				if (hit < 0 && cache_live[i] && cache_origin[i] == h.origin &&
					cache_seq[i] == h.seq)
					hit = i;
			if (hit >= 0) begin
				if (cache_hits[hit] == ffd_pkg::CNT_MAX)
					saturated_hits++;
				else
					cache_hits[hit] = cache_hits[hit] + ffd_pkg::CNT_ONE;
				v = ffd_pkg::V_DUPLICATE;
				n = cache_hits[hit];
			end else begin
				if (cache_fill >= DEPTH) begin
					slot = cache_oldest;
					cache_oldest = (cache_oldest + 1) % DEPTH;
					evictions++;
				end else begin
					slot = (cache_oldest + cache_fill) % DEPTH;
					cache_fill++;
				end
				cache_origin[slot] = h.origin;
				cache_seq[slot] = h.seq;
				cache_hits[slot] = ffd_pkg::CNT_ONE;
				cache_live[slot] = 1'b1;
				v = (h.qdst == cur_ip) ? ffd_pkg::V_DELIVER : ffd_pkg::V_FORWARD;
				n = ffd_pkg::CNT_ONE;
			end
		end
	endfunction

	function automatic step_t reg_step(input logic [ffd_pkg::CFG_IDX_W-1:0] idx,
		input logic [ffd_pkg::CFG_DATA_W-1:0] wdata);
		step_t s;
		s.kind = STEP_CFG;
		s.idx = idx;
		s.wdata = wdata;
		s.hdr = '0;
		s.fixed = 1'b0;
		s.verdict = ffd_pkg::V_BAD_TYPE;
		s.count = '0;
		return s;
	endfunction

	function automatic step_t probe_step(input logic [ffd_pkg::ETYPE_W-1:0] etype,
		input logic [ffd_pkg::MAC_W-1:0] mac, input logic [ffd_pkg::IP_W-1:0] origin,
		input logic [ffd_pkg::IP_W-1:0] qdst, input logic [ffd_pkg::SEQ_W-1:0] seq);
		step_t s;
		s = reg_step(REG_NONE, '0);
		s.kind = STEP_PKT;
		s.hdr.etype = etype;
		s.hdr.mac = mac;
		s.hdr.origin = origin;
		s.hdr.qdst = qdst;
		s.hdr.seq = seq;
		return s;
	endfunction

	function automatic step_t known_step(input logic [ffd_pkg::ETYPE_W-1:0] etype,
		input logic [ffd_pkg::MAC_W-1:0] mac, input logic [ffd_pkg::IP_W-1:0] origin,
		input logic [ffd_pkg::IP_W-1:0] qdst, input logic [ffd_pkg::SEQ_W-1:0] seq,
		input ffd_pkg::verdict_t verdict, input logic [ffd_pkg::CNT_W-1:0] count);
		step_t s;
		s = probe_step(etype, mac, origin, qdst, seq);
		s.fixed = 1'b1;
		s.verdict = verdict;
		s.count = count;
		return s;
	endfunction

	function automatic logic [ffd_pkg::CFG_DATA_W-1:0] reg_value(input int unsigned width);
		logic [ffd_pkg::CFG_DATA_W-1:0] mask;
		logic [ffd_pkg::CFG_DATA_W-1:0] pick;
		mask = (width >= ffd_pkg::CFG_DATA_W) ? '1 : ((48'd1 << width) - 48'd1);
		case ($urandom_range(0, 3))
			0: pick = '0;
			1: pick = '1;
			default: pick = {16'($urandom), $urandom};
		endcase
		return ({16'($urandom), $urandom} & ~mask) | (pick & mask);
	endfunction

	function automatic logic [ffd_pkg::MAC_W-1:0] other_mac();
		logic [ffd_pkg::MAC_W-1:0] m;
		m = {16'($urandom), $urandom};
		return (m == cur_mac) ? m ^ 48'h1 : m;
	endfunction

	task automatic send_header(input hdr_t h, input bit fixed, input ffd_pkg::verdict_t fv,
		input logic [ffd_pkg::CNT_W-1:0] fn);
		int unsigned gap;
		ffd_pkg::verdict_t v;
		logic [ffd_pkg::CNT_W-1:0] n;
		screen_res_t r;
		gap = src_busy ? $urandom_range(0, GAP_MAX) : 0;
		if (gap != 0) begin
			pkt_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pkt_in.valid <= 1'b1;
		pkt_in.pkt_ethertype <= h.etype;
		pkt_in.sender_mac <= h.mac;
		pkt_in.origin_addr <= h.origin;
		pkt_in.query_dst <= h.qdst;
		pkt_in.flood_seq <= h.seq;
		do @(posedge clk); while (!pkt_in.ready);
		screen_header(h, v, n);
		if (fixed) begin
			v = fv;
			n = fn;
		end
		r.verdict = v;
		r.count = n;
		pending = {pending, r};
		verdict_tally[v]++;
		headers_sent++;
	endtask

	task automatic settle();
		pkt_in.valid <= 1'b0;
		do @(posedge clk); while (pending.size() != 0);
	endtask

	task automatic write_reg(input logic [ffd_pkg::CFG_IDX_W-1:0] idx,
		input logic [ffd_pkg::CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			ffd_pkg::REG_FLOOD_ETYPE: cur_etype = data[ffd_pkg::ETYPE_W-1:0];
			ffd_pkg::REG_OWN_MAC:     cur_mac = data[ffd_pkg::MAC_W-1:0];
			ffd_pkg::REG_OWN_IP:      cur_ip = data[ffd_pkg::IP_W-1:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	always @(posedge clk) begin : result_sink
		int unsigned hold;
		screen_res_t want;
		if (arst_n) begin
			if (res_out.valid && res_out.ready) begin
				if (pending.size() == 0) begin
					$error("unexpected result: verdict %0d seen_count %0d",
						res_out.verdict, res_out.seen_count);
					fails++;
				end else begin
					want = pending[0];
					pending.delete(0);
					if (res_out.verdict !== want.verdict) begin
						$error("verdict: expected %0d, got %0d", want.verdict, res_out.verdict);
						fails++;
					end
					if (res_out.seen_count !== want.count) begin
						$error("seen_count: expected %0d, got %0d", want.count,
							res_out.seen_count);
						fails++;
					end
				end
				hold = snk_busy ? $urandom_range(0, GAP_MAX) : 0;
				if (hold != 0) begin
					res_out.ready <= 1'b0;
					sink_wait <= hold - 1;
				end
			end else if (!res_out.ready) begin
				if (sink_wait == 0)
					res_out.ready <= 1'b1;
				else
					sink_wait <= sink_wait - 1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((pkt_in.valid && pkt_in.ready) || (res_out.valid && res_out.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", idle_cycles);
				$display("status: fail");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		hdr_t h;
		flood_key_t k;
		int roll;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		pkt_in.valid = 1'b0;
		pkt_in.pkt_ethertype = '0;
		pkt_in.sender_mac = '0;
		pkt_in.origin_addr = '0;
		pkt_in.query_dst = '0;
		pkt_in.flood_seq = '0;
		res_out.ready = 1'b0;
		foreach (verdict_tally[i])
			verdict_tally[i] = 0;

		script = '{
			known_step(16'h0000, 48'h0, 32'h0, 32'h0, 32'h0,
				ffd_pkg::V_OWN_FRAME, 8'd0),
			known_step(16'hFFFF, 48'h1, 32'h0, 32'h0, 32'h0,
				ffd_pkg::V_BAD_TYPE, 8'd0),
			known_step(16'h0000, 48'h1, 32'h0, 32'h0, 32'h0,
				ffd_pkg::V_DELIVER, 8'd1),
			known_step(16'h0000, 48'h2, 32'h0, 32'h5, 32'h0,
				ffd_pkg::V_DUPLICATE, 8'd2),
			reg_step(ffd_pkg::REG_FLOOD_ETYPE, 48'hA5A5_0000_FFFF),
			reg_step(ffd_pkg::REG_OWN_MAC, 48'hFFFF_FFFF_FFFF),
			reg_step(ffd_pkg::REG_OWN_IP, 48'h1234_FFFF_FFFF),
			reg_step(REG_NONE, 48'h0),
			known_step(16'h0000, 48'h1, 32'h1, 32'h1, 32'h1,
				ffd_pkg::V_BAD_TYPE, 8'd0),
			known_step(16'hFFFF, 48'hFFFF_FFFF_FFFF, 32'h1, 32'h1, 32'h1,
				ffd_pkg::V_OWN_FRAME, 8'd0),
			known_step(16'hFFFF, 48'hFFFF_FFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
				32'hFFFF_FFFF, ffd_pkg::V_DELIVER, 8'd1),
			known_step(16'hFFFF, 48'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF,
				ffd_pkg::V_DUPLICATE, 8'd2),
			known_step(16'hFFFF, 48'h7FFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0,
				ffd_pkg::V_FORWARD, 8'd1),
			known_step(16'hFFFF, 48'h8000_0000_0000, 32'h0, 32'hFFFF_FFFF, 32'h0,
				ffd_pkg::V_DUPLICATE, 8'd3),
			known_step(16'hFFFF, 48'h5555_5555_5555, 32'h0, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
				ffd_pkg::V_FORWARD, 8'd1),
			known_step(16'hFFFF, 48'hFFFF_FFFF_FFFF, 32'h0, 32'h0, 32'h0,
				ffd_pkg::V_OWN_FRAME, 8'd0),
			known_step(16'h7FFF, 48'hFFFF_FFFF_FFFF, 32'h0, 32'h0, 32'h0,
				ffd_pkg::V_BAD_TYPE, 8'd0),
			probe_step(16'hFFFF, 48'hAAAA_AAAA_AAAA, 32'h0, 32'h0, 32'h0),
			reg_step(ffd_pkg::REG_FLOOD_ETYPE, 48'h0000_0000_88B5),
			reg_step(ffd_pkg::REG_OWN_MAC, 48'h0200_0000_0001),
			reg_step(ffd_pkg::REG_OWN_IP, 48'h0000_0A00_0001),
			probe_step(16'h88B5, 48'h0200_0000_0000, 32'h0A00_0002, 32'h0A00_0001, 32'h1),
			known_step(16'h88B4, 48'h0200_0000_0003, 32'h0A00_0002, 32'h0, 32'h1,
				ffd_pkg::V_BAD_TYPE, 8'd0),
			known_step(16'h88B5, 48'h0200_0000_0001, 32'h0A00_0002, 32'h0, 32'h1,
				ffd_pkg::V_OWN_FRAME, 8'd0),
			probe_step(16'h88B5, 48'h0300_0000_0001, 32'h0A00_0002, 32'h0A00_0003, 32'h2),
			probe_step(16'h88B5, 48'h0300_0000_0001, 32'h0A00_0003, 32'h0, 32'h1)
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].kind == STEP_CFG) begin
				settle();
				write_reg(script[i].idx, script[i].wdata);
			end else begin
				send_header(script[i].hdr, script[i].fixed, script[i].verdict, script[i].count);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			src_busy = $urandom_range(0, 3) != 0;
			snk_busy = $urandom_range(0, 3) != 0;
			write_reg(ffd_pkg::REG_FLOOD_ETYPE, reg_value(ffd_pkg::ETYPE_W));
			write_reg(ffd_pkg::REG_OWN_MAC, reg_value(ffd_pkg::MAC_W));
			write_reg(ffd_pkg::REG_OWN_IP, reg_value(ffd_pkg::IP_W));
			write_reg(REG_NONE, {16'($urandom), $urandom});
			if (ph == HAMMER_PHASE) begin
				h.origin = $urandom;
				h.seq = $urandom;
				repeat (HAMMER_ITEMS) begin
					h.etype = cur_etype;
					h.mac = other_mac();
					h.qdst = ($urandom_range(0, 1) == 0) ? cur_ip : $urandom;
					send_header(h, 1'b0, ffd_pkg::V_BAD_TYPE, '0);
				end
			end else begin
				repeat (PHASE_ITEMS) begin
					roll = $urandom_range(0, 99);
					h.etype = cur_etype;
					h.mac = other_mac();
					h.qdst = ($urandom_range(0, 2) == 0) ? cur_ip : $urandom;
					h.origin = $urandom;
					h.seq = $urandom;
					if (roll < 8) begin
						h.etype = cur_etype ^ 16'($urandom_range(1, 16'hFFFF));
					end else if (roll < 14) begin
						h.mac = cur_mac;
					end else if (recent_keys.size() != 0 && roll < 70) begin
						k = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
						if (roll < 54) begin
							h.origin = k.origin;
							h.seq = k.seq;
						end else if (roll[0]) begin
							h.origin = k.origin;
						end else begin
							h.seq = k.seq;
						end
					end
					if (roll >= 14) begin
						k.origin = h.origin;
						k.seq = h.seq;
						recent_keys = {recent_keys, k};
						if (recent_keys.size() > HISTORY_MAX)
							recent_keys.delete(0);
					end
					send_header(h, 1'b0, ffd_pkg::V_BAD_TYPE, '0);
				end
			end
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("%0d headers: %0d bad type, %0d own frame, %0d dup, %0d local, %0d fwd",
			headers_sent, verdict_tally[ffd_pkg::V_BAD_TYPE],
			verdict_tally[ffd_pkg::V_OWN_FRAME], verdict_tally[ffd_pkg::V_DUPLICATE],
			verdict_tally[ffd_pkg::V_DELIVER], verdict_tally[ffd_pkg::V_FORWARD]);
		$display("%0d register writes, %0d table evictions, %0d hits on a saturated count",
			reg_writes, evictions, saturated_hits);
		if (fails == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- flood_duplicate_filter.f -----
src/ffd_pkg.sv
src/ffd_if.sv
src/ffd_cell.sv
src/ffd_chain.sv
src/flood_duplicate_filter.sv
tb/sv/flood_duplicate_filter_tb.sv
